/* rtl/core/lws_pkg.sv */
// ----------------------------------------------------------------------------
// lws_pkg
// Shared types and constants of the windowed light statistics core.
// ----------------------------------------------------------------------------
`default_nettype none

package lws_pkg;

    // Fixed widths of the channel fields.
    localparam int FIELD_BITS     = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Defaults of the top level parameters.
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int WINDOW_MAX_DEF  = 255;

    // Depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Register reset values.
    localparam logic [7:0]         SAMPLE_COUNT_RST = 8'd1;
    localparam logic signed [15:0] IR_SCALE_RST     = 16'sd256;
    localparam logic [15:0]        VIS_SCALE_RST    = 16'd256;

    // Upper saturation value of unsigned lux.
    localparam logic [15:0] LUX_MAX = 16'hFFFF;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SAMPLE_COUNT   = 3'd0,
        REG_STREAMING_MODE = 3'd1,
        REG_IR_DARK        = 3'd2,
        REG_VIS_DARK       = 3'd3,
        REG_IR_SCALE       = 3'd4,
        REG_VIS_SCALE      = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [7:0]         sample_count;
        logic               streaming_mode;
        logic [15:0]        ir_dark;
        logic [15:0]        vis_dark;
        logic signed [15:0] ir_scale;
        logic [15:0]        vis_scale;
    } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/lws_if.sv */
// ----------------------------------------------------------------------------
// lws_if
// Handshake channels of the light statistics core: samples in, results out,
// and the register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lws_sample_if;
    logic                            valid;
    logic                            ready;
    logic [lws_pkg::FIELD_BITS-1:0]  vis_raw;
    logic [lws_pkg::FIELD_BITS-1:0]  ir_raw;
    logic [lws_pkg::FIELD_BITS-1:0]  uv_raw;

    modport source (output valid, output vis_raw, output ir_raw, output uv_raw, input ready);
    modport sink   (input valid, input vis_raw, input ir_raw, input uv_raw, output ready);
endinterface

interface lws_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lws_pkg::FIELD_BITS-1:0] avg_ir_lux;
    logic [lws_pkg::FIELD_BITS-1:0]        avg_vis_lux;
    logic [lws_pkg::FIELD_BITS-1:0]        avg_uv;
    logic signed [lws_pkg::FIELD_BITS-1:0] min_ir_lux;
    logic [lws_pkg::FIELD_BITS-1:0]        min_vis_lux;
    logic [lws_pkg::FIELD_BITS-1:0]        min_uv;
    logic signed [lws_pkg::FIELD_BITS-1:0] max_ir_lux;
    logic [lws_pkg::FIELD_BITS-1:0]        max_vis_lux;
    logic [lws_pkg::FIELD_BITS-1:0]        max_uv;

    modport source (
        output valid, output avg_ir_lux, output avg_vis_lux, output avg_uv,
        output min_ir_lux, output min_vis_lux, output min_uv,
        output max_ir_lux, output max_vis_lux, output max_uv,
        input ready
    );
    modport sink (
        input valid, input avg_ir_lux, input avg_vis_lux, input avg_uv,
        input min_ir_lux, input min_vis_lux, input min_uv,
        input max_ir_lux, input max_vis_lux, input max_uv,
        output ready
    );
endinterface

interface lws_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lws_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [lws_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/lws_cfg.sv */
// ----------------------------------------------------------------------------
// lws_cfg
// Register file: decodes register writes, derives the effective window
// length and flags a window restart after a count or mode write.
// ----------------------------------------------------------------------------
`default_nettype none

module lws_cfg #(
    parameter int   WINDOW_MAX = lws_pkg::WINDOW_MAX_DEF,
    localparam int  WIN_BITS   = $clog2(WINDOW_MAX + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    lws_cfg_if.sink                  cfg,
    output lws_pkg::cfg_t            cfg_q,
    output logic [WIN_BITS-1:0]      win_len,
    output logic                     restart
);

    localparam logic [7:0] WMAX8 = 8'(WINDOW_MAX);

    lws_pkg::cfg_t cfg_reg;
    logic          restart_reg;
    logic          wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;
    assign cfg_q     = cfg_reg;
    assign restart   = restart_reg;

    always_comb
    begin
        if (cfg_reg.sample_count == 8'd0)
        begin
            win_len = WIN_BITS'(1);
        end
        else if (cfg_reg.sample_count > WMAX8)
        begin
            win_len = WIN_BITS'(WINDOW_MAX);
        end
        else
        begin
            win_len = cfg_reg.sample_count[WIN_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_count   <= lws_pkg::SAMPLE_COUNT_RST;
            cfg_reg.streaming_mode <= 1'b0;
            cfg_reg.ir_dark        <= 16'd0;
            cfg_reg.vis_dark       <= 16'd0;
            cfg_reg.ir_scale       <= lws_pkg::IR_SCALE_RST;
            cfg_reg.vis_scale      <= lws_pkg::VIS_SCALE_RST;
            restart_reg            <= 1'b0;
        end
        else
        begin
            // A count or mode write drops the window that is being collected.
            restart_reg <= wr && ((cfg.index == lws_pkg::REG_SAMPLE_COUNT)
                                  || (cfg.index == lws_pkg::REG_STREAMING_MODE));
            if (wr)
            begin
                case (cfg.index)
                    lws_pkg::REG_SAMPLE_COUNT:
                    begin
                        cfg_reg.sample_count <= cfg.data[7:0];
                    end
                    lws_pkg::REG_STREAMING_MODE:
                    begin
                        cfg_reg.streaming_mode <= cfg.data[0];
                    end
                    lws_pkg::REG_IR_DARK:
                    begin
                        cfg_reg.ir_dark <= cfg.data;
                    end
                    lws_pkg::REG_VIS_DARK:
                    begin
                        cfg_reg.vis_dark <= cfg.data;
                    end
                    lws_pkg::REG_IR_SCALE:
                    begin
                        cfg_reg.ir_scale <= $signed(cfg.data);
                    end
                    lws_pkg::REG_VIS_SCALE:
                    begin
                        cfg_reg.vis_scale <= cfg.data;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/lws_front.sv */
// ----------------------------------------------------------------------------
// lws_front
// Sample intake: keeps per-channel sums, minima and maxima over the window
// and hands a finished window, or a single streamed sample, to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lws_front #(
    parameter int   SAMPLE_BITS = lws_pkg::SAMPLE_BITS_DEF,
    parameter int   WINDOW_MAX  = lws_pkg::WINDOW_MAX_DEF,
    localparam int  WIN_BITS    = $clog2(WINDOW_MAX + 1),
    localparam int  SUM_BITS    = SAMPLE_BITS + WIN_BITS,
    localparam int  LO_OFS      = 3 * SUM_BITS,
    localparam int  HI_OFS      = LO_OFS + 3 * SAMPLE_BITS,
    localparam int  DIV_OFS     = HI_OFS + 3 * SAMPLE_BITS,
    localparam int  JOB_BITS    = DIV_OFS + WIN_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    lws_sample_if.sink                samples,
    input  wire lws_pkg::cfg_t        cfg_q,
    input  wire logic [WIN_BITS-1:0]  win_len,
    input  wire logic                 restart,
    input  wire logic                 q_full,
    output logic                      push,
    output logic [JOB_BITS-1:0]       push_data
);

    // Channel order in all arrays: visible, infrared, UV.
    logic [SUM_BITS-1:0]    sum_reg [3];
    logic [SAMPLE_BITS-1:0] lo_reg  [3];
    logic [SAMPLE_BITS-1:0] hi_reg  [3];
    logic [WIN_BITS-1:0]    left_reg;

    logic [SAMPLE_BITS-1:0] smp     [3];
    logic [SUM_BITS-1:0]    sum_acc [3];
    logic [SAMPLE_BITS-1:0] lo_acc  [3];
    logic [SAMPLE_BITS-1:0] hi_acc  [3];
    logic                   last;
    logic                   accept;

    always_comb
    begin
        smp[0] = samples.vis_raw[SAMPLE_BITS-1:0];
        smp[1] = samples.ir_raw[SAMPLE_BITS-1:0];
        smp[2] = samples.uv_raw[SAMPLE_BITS-1:0];
        for (int c = 0; c < 3; c++)
        begin
            sum_acc[c] = sum_reg[c] + SUM_BITS'(smp[c]);
            lo_acc[c]  = (smp[c] < lo_reg[c]) ? smp[c] : lo_reg[c];
            hi_acc[c]  = (smp[c] > hi_reg[c]) ? smp[c] : hi_reg[c];
        end
    end

    assign last = (left_reg == WIN_BITS'(1));

    // A beat that only accumulates needs no queue slot.
    assign samples.ready = !restart && (!q_full || (!cfg_q.streaming_mode && !last));
    assign accept        = samples.valid && samples.ready;
    assign push          = accept && (cfg_q.streaming_mode || last);

    always_comb
    begin
        push_data = '0;
        for (int c = 0; c < 3; c++)
        begin
            if (cfg_q.streaming_mode)
            begin
                push_data[c*SUM_BITS +: SUM_BITS]                 = SUM_BITS'(smp[c]);
                push_data[LO_OFS + c*SAMPLE_BITS +: SAMPLE_BITS]  = smp[c];
                push_data[HI_OFS + c*SAMPLE_BITS +: SAMPLE_BITS]  = smp[c];
            end
            else
            begin
                push_data[c*SUM_BITS +: SUM_BITS]                 = sum_acc[c];
                push_data[LO_OFS + c*SAMPLE_BITS +: SAMPLE_BITS]  = lo_acc[c];
                push_data[HI_OFS + c*SAMPLE_BITS +: SAMPLE_BITS]  = hi_acc[c];
            end
        end
        push_data[DIV_OFS +: WIN_BITS] = cfg_q.streaming_mode ? WIN_BITS'(1) : win_len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= WIN_BITS'(1);
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= '0;
                lo_reg[c]  <= '1;
                hi_reg[c]  <= '0;
            end
        end
        else if (restart || (accept && !cfg_q.streaming_mode && last))
        begin
            left_reg <= win_len;
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= '0;
                lo_reg[c]  <= '1;
                hi_reg[c]  <= '0;
            end
        end
        else if (accept && !cfg_q.streaming_mode)
        begin
            left_reg <= left_reg - WIN_BITS'(1);
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= sum_acc[c];
                lo_reg[c]  <= lo_acc[c];
                hi_reg[c]  <= hi_acc[c];
            end
        end
    end

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("window result pushed into a full queue");

    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg != '0)
        else $error("window sample counter reached zero");

endmodule

`default_nettype wire

/* rtl/core/lws_queue.sv */
// ----------------------------------------------------------------------------
// lws_queue
// Short job queue that decouples sample intake from the result engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lws_queue #(
    parameter int   DATA_BITS = 8,
    parameter int   DEPTH     = lws_pkg::QUEUE_DEPTH,
    localparam int  PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int  CNT_BITS  = $clog2(DEPTH + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire logic [DATA_BITS-1:0]  push_data,
    input  wire logic                  pop,
    output logic [DATA_BITS-1:0]       pop_data,
    output logic                       full,
    output logic                       empty
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg;
    logic [PTR_BITS-1:0]  rd_ptr_reg;
    logic [CNT_BITS-1:0]  count_reg;

    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + PTR_BITS'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_BITS'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_BITS'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/lws_back.sv */
// ----------------------------------------------------------------------------
// lws_back
// Result engine: divides the window sums bit by bit, converts averages and
// extremes to lux on one shared multiplier and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module lws_back #(
    parameter int   SAMPLE_BITS = lws_pkg::SAMPLE_BITS_DEF,
    parameter int   WINDOW_MAX  = lws_pkg::WINDOW_MAX_DEF,
    localparam int  WIN_BITS    = $clog2(WINDOW_MAX + 1),
    localparam int  SUM_BITS    = SAMPLE_BITS + WIN_BITS,
    localparam int  LO_OFS      = 3 * SUM_BITS,
    localparam int  HI_OFS      = LO_OFS + 3 * SAMPLE_BITS,
    localparam int  DIV_OFS     = HI_OFS + 3 * SAMPLE_BITS,
    localparam int  JOB_BITS    = DIV_OFS + WIN_BITS,
    localparam int  CNT_BITS    = $clog2(SUM_BITS)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_empty,
    output logic                      pop,
    input  wire logic [JOB_BITS-1:0]  pop_data,
    input  wire lws_pkg::cfg_t        cfg_q,
    lws_result_if.source              results
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_LUX  = 4'b0100,
        ST_DONE = 4'b1000
    } back_state_t;

    // Six multiplies (infrared then visible for average, min, max) plus a final
    // step to drain the product register.
    localparam logic [2:0] LUX_LAST = 3'd6;

    back_state_t            state_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic [2:0]             step_reg;

    logic [SUM_BITS-1:0]    quo_reg [3];
    logic [WIN_BITS-1:0]    rem_reg [3];
    logic [WIN_BITS-1:0]    div_reg;
    logic [SAMPLE_BITS-1:0] lo_reg  [3];
    logic [SAMPLE_BITS-1:0] hi_reg  [3];
    logic signed [33:0]     prod_reg;
    logic signed [15:0]     ir_lux_reg  [3];
    logic [15:0]            vis_lux_reg [3];

    logic [SUM_BITS-1:0]    quo_step [3];
    logic [WIN_BITS-1:0]    rem_step [3];

    logic [1:0]             mul_t;
    logic                   mul_vis;
    logic [15:0]            raw_vis;
    logic [15:0]            raw_ir;
    logic [15:0]            raw;
    logic [15:0]            dark;
    logic [15:0]            diff;
    logic signed [16:0]     mul_a;
    logic signed [16:0]     mul_b;
    logic signed [33:0]     mul_out;

    logic [2:0]             post_idx;
    logic [1:0]             post_t;
    logic                   post_vis;
    logic signed [33:0]     p_adj;
    logic signed [25:0]     p_sh;
    logic signed [15:0]     ir_res;
    logic [15:0]            v_sat;
    logic signed [17:0]     v_sum;
    logic [15:0]            vis_res;

    assign pop = (state_reg == ST_IDLE) && !q_empty;

    // One restoring division step per channel.
    always_comb
    begin
        logic [WIN_BITS:0] trial;
        for (int c = 0; c < 3; c++)
        begin
            trial = {rem_reg[c], quo_reg[c][SUM_BITS-1]};
            if (trial >= {1'b0, div_reg})
            begin
                rem_step[c] = WIN_BITS'(trial - {1'b0, div_reg});
                quo_step[c] = {quo_reg[c][SUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_step[c] = trial[WIN_BITS-1:0];
                quo_step[c] = {quo_reg[c][SUM_BITS-2:0], 1'b0};
            end
        end
    end

    // Operand selection and the shared multiplier.
    assign mul_t   = step_reg[2:1];
    assign mul_vis = step_reg[0];

    always_comb
    begin
        case (mul_t)
            2'd0:
            begin
                raw_vis = 16'(quo_reg[0][SAMPLE_BITS-1:0]);
                raw_ir  = 16'(quo_reg[1][SAMPLE_BITS-1:0]);
            end
            2'd1:
            begin
                raw_vis = 16'(lo_reg[0]);
                raw_ir  = 16'(lo_reg[1]);
            end
            default:
            begin
                raw_vis = 16'(hi_reg[0]);
                raw_ir  = 16'(hi_reg[1]);
            end
        endcase
    end

    assign raw     = mul_vis ? raw_vis : raw_ir;
    assign dark    = mul_vis ? cfg_q.vis_dark : cfg_q.ir_dark;
    assign diff    = (raw > dark) ? (raw - dark) : 16'd0;
    assign mul_a   = $signed({1'b0, diff});
    assign mul_b   = mul_vis ? $signed({1'b0, cfg_q.vis_scale})
                             : $signed({cfg_q.ir_scale[15], cfg_q.ir_scale});
    assign mul_out = mul_a * mul_b;

    // Scaling and saturation of the product from the previous step.
    assign post_idx = step_reg - 3'd1;
    assign post_t   = post_idx[2:1];
    assign post_vis = post_idx[0];

    always_comb
    begin
        // Bias negative products so the shift truncates toward zero.
        p_adj = prod_reg + (prod_reg[33] ? 34'sd255 : 34'sd0);
        p_sh  = p_adj[33:8];
        if (p_sh > 26'sd32767)
        begin
            ir_res = 16'sh7FFF;
        end
        else if (p_sh < -26'sd32768)
        begin
            ir_res = 16'sh8000;
        end
        else
        begin
            ir_res = p_sh[15:0];
        end

        v_sat = (|prod_reg[31:24]) ? lws_pkg::LUX_MAX : prod_reg[23:8];
        v_sum = $signed({2'b00, v_sat})
              + $signed({{2{ir_lux_reg[post_t][15]}}, ir_lux_reg[post_t]});
        if (v_sum[17])
        begin
            vis_res = 16'd0;
        end
        else if (v_sum[16])
        begin
            vis_res = lws_pkg::LUX_MAX;
        end
        else
        begin
            vis_res = v_sum[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= ST_DIV;
                        cnt_reg   <= CNT_BITS'(SUM_BITS - 1);
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg - CNT_BITS'(1);
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_LUX;
                        step_reg  <= '0;
                    end
                end
                ST_LUX:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == LUX_LAST)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (results.ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            div_reg <= pop_data[DIV_OFS +: WIN_BITS];
            for (int c = 0; c < 3; c++)
            begin
                quo_reg[c] <= pop_data[c*SUM_BITS +: SUM_BITS];
                rem_reg[c] <= '0;
                lo_reg[c]  <= pop_data[LO_OFS + c*SAMPLE_BITS +: SAMPLE_BITS];
                hi_reg[c]  <= pop_data[HI_OFS + c*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
        else if (state_reg == ST_DIV)
        begin
            for (int c = 0; c < 3; c++)
            begin
                quo_reg[c] <= quo_step[c];
                rem_reg[c] <= rem_step[c];
            end
        end

        if (state_reg == ST_LUX)
        begin
            if (step_reg != LUX_LAST)
            begin
                prod_reg <= mul_out;
            end
            if (step_reg != 3'd0)
            begin
                if (post_vis)
                begin
                    vis_lux_reg[post_t] <= vis_res;
                end
                else
                begin
                    ir_lux_reg[post_t] <= ir_res;
                end
            end
        end
    end

    assign results.valid       = (state_reg == ST_DONE);
    assign results.avg_ir_lux  = ir_lux_reg[0];
    assign results.avg_vis_lux = vis_lux_reg[0];
    assign results.avg_uv      = 16'(quo_reg[2][SAMPLE_BITS-1:0]);
    assign results.min_ir_lux  = ir_lux_reg[1];
    assign results.min_vis_lux = vis_lux_reg[1];
    assign results.min_uv      = 16'(lo_reg[2]);
    assign results.max_ir_lux  = ir_lux_reg[2];
    assign results.max_vis_lux = vis_lux_reg[2];
    assign results.max_uv      = 16'(hi_reg[2]);

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_reg != '0))
        else $error("window division started with a zero divisor");

    a_lux_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LUX) |-> (step_reg <= LUX_LAST))
        else $error("lux sequencer ran past its last step");

    a_lux_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_LUX) && (step_reg == LUX_LAST)) |=> results.valid)
        else $error("lux sequence finished without presenting a result");

endmodule

`default_nettype wire

/* rtl/core/light_window_stats_lux_core.sv */
// ----------------------------------------------------------------------------
// light_window_stats_lux_core
// Windowed average, minimum and maximum of visible, infrared and UV readings
// with dark offset removal and lux scaling.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  cfg       in         register index, 16-bit write data
//  samples   in         vis_raw, ir_raw, uv_raw
//  results   out        avg/min/max of ir lux, vis lux and uv
//
//  A sample beat is taken on its handshake; the front accumulates it at once.
//  A finished window or streamed sample is popped as a job, divided one
//  quotient bit a cycle, converted to lux on the shared multiplier and held
//  as a result beat; the back pops no new job until that beat is taken.
//  A two-entry job queue lets the front keep taking beats while the back is
//  busy or a result waits; the front stalls only when a result-producing
//  beat finds the queue full, and in the cycle after a count or mode write.
//  Reset restores settings, control state, an empty window; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module light_window_stats_lux_core #(
    parameter int SAMPLE_BITS = lws_pkg::SAMPLE_BITS_DEF,
    parameter int WINDOW_MAX  = lws_pkg::WINDOW_MAX_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    lws_cfg_if.sink       cfg,
    lws_sample_if.sink    samples,
    lws_result_if.source  results
);

    localparam int WIN_BITS = $clog2(WINDOW_MAX + 1);
    localparam int SUM_BITS = SAMPLE_BITS + WIN_BITS;
    localparam int JOB_BITS = 3 * SUM_BITS + 6 * SAMPLE_BITS + WIN_BITS;

    lws_pkg::cfg_t         cfg_q;
    logic [WIN_BITS-1:0]   win_len;
    logic                  restart;
    logic                  push;
    logic [JOB_BITS-1:0]   push_data;
    logic                  pop;
    logic [JOB_BITS-1:0]   pop_data;
    logic                  q_full;
    logic                  q_empty;

    lws_cfg #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_q   (cfg_q),
        .win_len (win_len),
        .restart (restart)
    );

    lws_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WINDOW_MAX  (WINDOW_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .cfg_q     (cfg_q),
        .win_len   (win_len),
        .restart   (restart),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    lws_queue #(
        .DATA_BITS (JOB_BITS),
        .DEPTH     (lws_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    lws_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WINDOW_MAX  (WINDOW_MAX)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .pop      (pop),
        .pop_data (pop_data),
        .cfg_q    (cfg_q),
        .results  (results)
    );

endmodule

`default_nettype wire

/* bench/light_window_stats_lux_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// light_window_stats_lux_core_test
// Self-checking bench for the windowed light statistics core. Readings are
// pushed through the sample channel under several register settings. A
// scoreboard predicts every result beat from its own copy of the registers
// and window stores. Each result beat is checked field by field in order.
// ----------------------------------------------------------------------------
module light_window_stats_lux_core_test;

    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 1_000_000;
    // Extra wait after the last pending result has been checked; leave some margin.
    localparam int DRAIN_CYCLES = 48;
    localparam int RANDOM_ITEMS = 1100;
    localparam int BIG_PHASE    = 3;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [lws_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [lws_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic signed [15:0] avg_ir_lux;
        logic [15:0]        avg_vis_lux;
        logic [15:0]        avg_uv;
        logic signed [15:0] min_ir_lux;
        logic [15:0]        min_vis_lux;
        logic [15:0]        min_uv;
        logic signed [15:0] max_ir_lux;
        logic [15:0]        max_vis_lux;
        logic [15:0]        max_uv;
    } light_stats_t;

    class lux_stats_scoreboard;
        lws_pkg::cfg_t regs;
        logic [7:0]    samples_left;
        logic [23:0]   vis_sum, ir_sum, uv_sum;
        logic [15:0]   vis_high, ir_high, uv_high;
        logic [15:0]   vis_low, ir_low, uv_low;
        light_stats_t  expected_stats[$];
        int            mismatches;

        function new();
            regs.sample_count   = lws_pkg::SAMPLE_COUNT_RST;
            regs.streaming_mode = 1'b0;
            regs.ir_dark        = '0;
            regs.vis_dark       = '0;
            regs.ir_scale       = lws_pkg::IR_SCALE_RST;
            regs.vis_scale      = lws_pkg::VIS_SCALE_RST;
            mismatches          = 0;
            clear_window();
        endfunction

        function int window_len();
            int n;
            n = regs.sample_count;
            if (n < 1)
                n = 1;
            if (n > lws_pkg::WINDOW_MAX_DEF)
                n = lws_pkg::WINDOW_MAX_DEF;
            return n;
        endfunction

        function void clear_window();
            samples_left = 8'(window_len());
            vis_sum  = '0;
            ir_sum   = '0;
            uv_sum   = '0;
            vis_high = '0;
            ir_high  = '0;
            uv_high  = '0;
            vis_low  = lws_pkg::LUX_MAX;
            ir_low   = lws_pkg::LUX_MAX;
            uv_low   = lws_pkg::LUX_MAX;
        endfunction

        function void apply_write(logic [lws_pkg::CFG_INDEX_BITS-1:0] idx, logic [15:0] data);
            case (idx)
                lws_pkg::REG_SAMPLE_COUNT:
                begin
                    regs.sample_count = data[7:0];
                    clear_window();
                end
                lws_pkg::REG_STREAMING_MODE:
                begin
                    regs.streaming_mode = data[0];
                    clear_window();
                end
                lws_pkg::REG_IR_DARK:   regs.ir_dark   = data;
                lws_pkg::REG_VIS_DARK:  regs.vis_dark  = data;
                lws_pkg::REG_IR_SCALE:  regs.ir_scale  = data;
                lws_pkg::REG_VIS_SCALE: regs.vis_scale = data;
                default: ;
            endcase
        endfunction

        // Dark removal floors at zero; the signed product truncates toward zero.
        function logic signed [15:0] ir_to_lux(logic [15:0] raw);
            longint diff, prod;
            diff = (raw > regs.ir_dark) ? longint'(raw) - longint'(regs.ir_dark) : 0;
            prod = (diff * longint'($signed(regs.ir_scale))) / 256;
            if (prod > 32767)
                prod = 32767;
            if (prod < -32768)
                prod = -32768;
            return 16'(prod);
        endfunction

        // The visible part saturates on its own before the infrared lux is added.
        function logic [15:0] vis_to_lux(logic [15:0] raw, logic signed [15:0] irl);
            longint diff, lux;
            diff = (raw > regs.vis_dark) ? longint'(raw) - longint'(regs.vis_dark) : 0;
            lux = (diff * longint'(regs.vis_scale)) / 256;
            if (lux > 65535)
                lux = 65535;
            lux = lux + longint'(irl);
            if (lux > 65535)
                lux = 65535;
            if (lux < 0)
                lux = 0;
            return 16'(lux);
        endfunction

        function void note_reading(logic [15:0] vis, logic [15:0] ir, logic [15:0] uv);
            light_stats_t want;
            int           n;
            logic [15:0]  vis_avg, ir_avg, uv_avg;
            if (regs.streaming_mode)
            begin
                want.avg_ir_lux  = ir_to_lux(ir);
                want.avg_vis_lux = vis_to_lux(vis, want.avg_ir_lux);
                want.avg_uv      = uv;
                want.min_ir_lux  = want.avg_ir_lux;
                want.min_vis_lux = want.avg_vis_lux;
                want.min_uv      = uv;
                want.max_ir_lux  = want.avg_ir_lux;
                want.max_vis_lux = want.avg_vis_lux;
                want.max_uv      = uv;
                expected_stats.push_back(want);
                return;
            end
            vis_sum = vis_sum + vis;
            ir_sum  = ir_sum + ir;
            uv_sum  = uv_sum + uv;
            if (vis > vis_high)
                vis_high = vis;
            if (ir > ir_high)
                ir_high = ir;
            if (uv > uv_high)
                uv_high = uv;
            if (vis < vis_low)
                vis_low = vis;
            if (ir < ir_low)
                ir_low = ir;
            if (uv < uv_low)
                uv_low = uv;
            if (samples_left > 1)
            begin
                samples_left = samples_left - 1;
                return;
            end
            n       = window_len();
            vis_avg = 16'(vis_sum / n);
            ir_avg  = 16'(ir_sum / n);
            uv_avg  = 16'(uv_sum / n);
            want.avg_ir_lux  = ir_to_lux(ir_avg);
            want.avg_vis_lux = vis_to_lux(vis_avg, want.avg_ir_lux);
            want.avg_uv      = uv_avg;
            want.min_ir_lux  = ir_to_lux(ir_low);
            want.min_vis_lux = vis_to_lux(vis_low, want.min_ir_lux);
            want.min_uv      = uv_low;
            want.max_ir_lux  = ir_to_lux(ir_high);
            want.max_vis_lux = vis_to_lux(vis_high, want.max_ir_lux);
            want.max_uv      = uv_high;
            expected_stats.push_back(want);
            clear_window();
        endfunction

        task report(string msg);
            $display("ERROR at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s is %h, expected %h", name, got, want));
        endtask

        task check_stats(light_stats_t got);
            light_stats_t want;
            if (expected_stats.size() == 0)
            begin
                report("result beat with no expected result pending");
                return;
            end
            want = expected_stats.pop_front();
            compare_field("avg_ir_lux", got.avg_ir_lux, want.avg_ir_lux);
            compare_field("avg_vis_lux", got.avg_vis_lux, want.avg_vis_lux);
            compare_field("avg_uv", got.avg_uv, want.avg_uv);
            compare_field("min_ir_lux", got.min_ir_lux, want.min_ir_lux);
            compare_field("min_vis_lux", got.min_vis_lux, want.min_vis_lux);
            compare_field("min_uv", got.min_uv, want.min_uv);
            compare_field("max_ir_lux", got.max_ir_lux, want.max_ir_lux);
            compare_field("max_vis_lux", got.max_vis_lux, want.max_vis_lux);
            compare_field("max_uv", got.max_uv, want.max_uv);
        endtask
    endclass

    logic clk;
    logic rst_n;

    lws_cfg_if    cfg_ch();
    lws_sample_if smp_ch();
    lws_result_if res_ch();

    lux_stats_scoreboard stats_book;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int cycle_count;

    light_window_stats_lux_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .samples (smp_ch),
        .results (res_ch)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("light_window_stats_lux_core test failed");
            $finish;
        end
    end

    // Result sink: random stalls, or a long hold-off when one is requested.
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Both sides of the result channel only change at rising edges, so a
    // beat that shows valid and ready at the falling edge is taken at the
    // next rising edge.
    always @(negedge clk)
    begin : result_monitor
        light_stats_t beat;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            beat.avg_ir_lux  = res_ch.avg_ir_lux;
            beat.avg_vis_lux = res_ch.avg_vis_lux;
            beat.avg_uv      = res_ch.avg_uv;
            beat.min_ir_lux  = res_ch.min_ir_lux;
            beat.min_vis_lux = res_ch.min_vis_lux;
            beat.min_uv      = res_ch.min_uv;
            beat.max_ir_lux  = res_ch.max_ir_lux;
            beat.max_vis_lux = res_ch.max_vis_lux;
            beat.max_uv      = res_ch.max_uv;
            stats_book.check_stats(beat);
        end
    end

    task automatic send_reading(logic [15:0] vis, logic [15:0] ir, logic [15:0] uv);
        logic took;
        while ($urandom_range(99) < send_idle_pct)
        begin
            smp_ch.valid <= 1'b0;
            @(posedge clk);
        end
        smp_ch.valid   <= 1'b1;
        smp_ch.vis_raw <= vis;
        smp_ch.ir_raw  <= ir;
        smp_ch.uv_raw  <= uv;
        // Ready is settled by the falling edge and holds until the next
        // rising edge, where the beat is taken.
        do
        begin
            @(negedge clk);
            took = (smp_ch.ready === 1'b1);
            @(posedge clk);
        end
        while (!took);
        stats_book.note_reading(vis, ir, uv);
    endtask

    task automatic write_reg(logic [lws_pkg::CFG_INDEX_BITS-1:0] idx, logic [15:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        stats_book.apply_write(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering readings and let every pending result drain out.
    task automatic quiesce();
        smp_ch.valid <= 1'b0;
        @(posedge clk);
        while (stats_book.expected_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_reading();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_dark();
        case ($urandom_range(3))
            0, 1: return 16'h0000;
            2: return 16'($urandom_range(0, 4095));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [7:0] pick_count(int phase);
        int r;
        r = $urandom_range(99);
        if (phase == BIG_PHASE)
            return 8'd255;
        if (r < 6)
            return 8'd0;
        if (r < 70)
            return 8'($urandom_range(1, 6));
        return 8'($urandom_range(7, 24));
    endfunction

    // Writes a fresh random setting and returns how many readings to send.
    task automatic random_setup(int phase, output int items);
        logic [7:0]  count;
        logic [15:0] word;
        logic        stream;
        int          n;
        write_reg(lws_pkg::REG_IR_DARK, pick_dark());
        write_reg(lws_pkg::REG_VIS_DARK, pick_dark());
        case ($urandom_range(5))
            0: word = 16'h8000;
            1: word = 16'h7FFF;
            2: word = 16'h0100;
            3: word = 16'hFF00;
            default: word = 16'($urandom_range(0, 65535));
        endcase
        write_reg(lws_pkg::REG_IR_SCALE, word);
        case ($urandom_range(4))
            0: word = 16'h0000;
            1: word = 16'hFFFF;
            2: word = 16'h0100;
            3: word = 16'($urandom_range(0, 1023));
            default: word = 16'($urandom_range(0, 65535));
        endcase
        write_reg(lws_pkg::REG_VIS_SCALE, word);
        if ($urandom_range(9) == 0)
            write_reg($urandom_range(1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                      16'($urandom_range(0, 65535)));
        stream = ($urandom_range(3) == 0) && (phase != BIG_PHASE);
        write_reg(lws_pkg::REG_STREAMING_MODE, {15'($urandom_range(0, 32767)), stream});
        count = pick_count(phase);
        write_reg(lws_pkg::REG_SAMPLE_COUNT, {8'($urandom_range(0, 255)), count});
        n = (count == 0) ? 1 : count;
        if (stream)
            items = $urandom_range(4, 16);
        else if (n > 24)
            items = n;
        else
        begin
            items = n * $urandom_range(1, 4);
            // Now and then leave a window half full; the next mode or count write drops it.
            if (n > 1 && $urandom_range(6) == 0)
                items = items + $urandom_range(1, n - 1);
        end
    endtask

    initial
    begin
        int sent;
        int items;
        int phase;

        stats_book     = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        send_idle_pct  = 20;
        recv_idle_pct  = 67;
        hold_left      = 0;
        cycle_count    = 0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        smp_ch.valid   = 1'b0;
        smp_ch.vis_raw = '0;
        smp_ch.ir_raw  = '0;
        smp_ch.uv_raw  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: window of one reading, unit scales, no dark offset.
        send_reading(16'h0000, 16'h0000, 16'h0000);
        send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_reading(16'h1234, 16'h0001, 16'h8000);
        quiesce();

        // Negative infrared scale: the minimum lux ends up above the maximum.
        // Readings below the dark values floor at zero.
        write_reg(lws_pkg::REG_IR_DARK, 16'h1000);
        write_reg(lws_pkg::REG_VIS_DARK, 16'h2000);
        write_reg(lws_pkg::REG_IR_SCALE, 16'h8000);
        write_reg(lws_pkg::REG_VIS_SCALE, 16'hFFFF);
        write_reg(lws_pkg::REG_STREAMING_MODE, 16'h0000);
        write_reg(lws_pkg::REG_SAMPLE_COUNT, 16'hA504);
        send_reading(16'h1FFF, 16'h0FFF, 16'h0010);
        send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_reading(16'h2001, 16'h1001, 16'h0000);
        send_reading(16'h8000, 16'h8000, 16'h5555);
        quiesce();

        // A count write in the middle of a window drops the partial window.
        write_reg(lws_pkg::REG_SAMPLE_COUNT, 16'h0003);
        send_reading(16'hFFFF, 16'h0000, 16'hFFFF);
        send_reading(16'h0000, 16'hFFFF, 16'h0000);
        quiesce();
        write_reg(lws_pkg::REG_SAMPLE_COUNT, 16'h0003);
        send_reading(16'h3000, 16'h2000, 16'h0100);
        send_reading(16'h4000, 16'h1800, 16'h0300);
        send_reading(16'h5000, 16'h3000, 16'h0200);
        quiesce();

        // A count of zero behaves as a count of one.
        write_reg(lws_pkg::REG_SAMPLE_COUNT, 16'hFF00);
        write_reg(lws_pkg::REG_IR_SCALE, 16'h7FFF);
        write_reg(lws_pkg::REG_VIS_SCALE, 16'h0000);
        send_reading(16'hFFFF, 16'hFFFF, 16'h0001);
        send_reading(16'h0000, 16'h1100, 16'hFFFE);
        quiesce();

        write_reg(REG_UNMAPPED_LO, 16'hFFFF);
        write_reg(REG_UNMAPPED_HI, 16'h5A5A);
        send_reading(16'h2345, 16'h6789, 16'hABCD);
        quiesce();

        write_reg(lws_pkg::REG_STREAMING_MODE, 16'h0001);
        send_reading(16'h0000, 16'hFFFF, 16'h0000);
        send_reading(16'hFFFF, 16'h0000, 16'hFFFF);
        send_reading(16'h8001, 16'h7FFE, 16'h1234);
        quiesce();

        // Hold the result side off while readings keep coming, so the job
        // queue fills and the sample channel has to stall.
        send_idle_pct = 0;
        hold_left     = 400;
        repeat (12) send_reading(pick_reading(), pick_reading(), pick_reading());
        quiesce();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 20;
                recv_idle_pct = 67;
            end
            else if (sent < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 67;
                recv_idle_pct = 20;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_setup(phase, items);
            repeat (items) send_reading(pick_reading(), pick_reading(), pick_reading());
            sent  = sent + items;
            phase = phase + 1;
            quiesce();
        end

        if (stats_book.mismatches == 0)
            $display("light_window_stats_lux_core test passed");
        else
            $display("light_window_stats_lux_core test failed");
        $finish;
    end

endmodule
